[rtl/core/efr_pkg.sv]
// ----------------------------------------------------------------------------
// efr_pkg
// Constants, codes and the checksum fold for the escaped frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package efr_pkg;

    // overfill bound on the byte count
    localparam logic [7:0] MAX_FILL   = 8'd250;

    localparam logic [7:0] ESC_BYTE   = 8'hD7;
    localparam logic [7:0] START_BYTE = 8'h29;
    localparam logic [7:0] CHECK_XOR  = 8'h3C;
    localparam logic [7:0] COLON_BYTE = 8'h3A;
    localparam logic [7:0] STUFF_BYTE = 8'h00;

    // buffer positions with a meaning
    localparam logic [7:0] POS_LEGACY_LEN = 8'd1;
    localparam logic [7:0] POS_START      = 8'd2;
    localparam logic [7:0] POS_ADDRESS    = 8'd3;
    localparam logic [7:0] POS_LENGTH     = 8'd5;
    localparam logic [7:0] HEADER_BYTES   = 8'd6;
    localparam logic [7:0] LEGACY_EXTRA   = 8'd2;
    localparam logic [7:0] START_COUNT    = 8'd3;

    typedef enum logic {
        CFG_DEVICE_ADDRESS = 1'b0,
        CFG_PROTOCOL_MODE  = 1'b1
    } t_cfg_index;

    typedef enum logic {
        MODE_LEGACY  = 1'b0,
        MODE_ESCAPED = 1'b1
    } t_mode;

    localparam logic [7:0] RESET_ADDRESS = 8'd15;

    typedef struct packed {
        logic       byte_kept;
        logic [7:0] kept_byte;
        logic [7:0] kept_index;
        logic       frame_start;
        logic       frame_done;
        logic       checksum_ok;
        logic       address_ok;
        logic [7:0] frame_bytes;
    } t_result;

    // xor, rotate right by one, xor 0x3C when the top bit lands set
    function automatic logic [7:0] fold(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] x;
        x = c ^ b;
        x = {x[0], x[7:1]};
        if (x[7]) begin
            x = x ^ CHECK_XOR;
        end
        return x;
    endfunction

    // checksum after the seeded 00 D7 of a start pair
    localparam logic [7:0] START_CHECK = fold(fold(8'h00, STUFF_BYTE), ESC_BYTE);

endpackage

`default_nettype wire

[rtl/core/escaped_frame_receiver.sv]
// ----------------------------------------------------------------------------
// escaped_frame_receiver
// Byte-wise frame receiver with escaped start pairs, checksum and address check, plus a legacy mode.
// ----------------------------------------------------------------------------
// Takes one received byte per item and returns one result item per byte. An
// item is taken in every cycle while the result register is free or draining;
// its result is registered on acceptance and appears in the next cycle.
// Configuration writes are registered and are to be made only while no item
// is in flight.
`default_nettype none

module escaped_frame_receiver (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    // byte input
    input  wire logic       i_rx_valid,
    output logic            o_rx_stall,
    input  wire logic [7:0] i_rx_byte,
    // result output
    output logic            o_res_valid,
    input  wire logic       i_res_stall,
    output logic            o_byte_kept,
    output logic [7:0]      o_kept_byte,
    output logic [7:0]      o_kept_index,
    output logic            o_frame_start,
    output logic            o_frame_done,
    output logic            o_checksum_ok,
    output logic            o_address_ok,
    output logic [7:0]      o_frame_bytes
);

    logic [7:0]           r_dev_addr;
    efr_pkg::t_mode       r_mode;

    logic [7:0] r_count,   n_count;
    logic       r_esc,     n_esc;
    logic       r_started, n_started;
    logic [7:0] r_pay_len, n_pay_len;
    logic [7:0] r_check,   n_check;
    logic [7:0] r_leg_len, n_leg_len;
    logic [7:0] r_addr,    n_addr;
    logic [7:0] r_last,    n_last;

    efr_pkg::t_result r_res, n_res;
    logic             r_out_valid;

    logic       rx_acc;
    logic       store;
    logic [7:0] cnt0;
    logic [7:0] cnt1;

    assign o_rx_stall = r_out_valid && i_res_stall;
    assign rx_acc     = i_rx_valid && !o_rx_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= efr_pkg::RESET_ADDRESS;
            r_mode     <= efr_pkg::MODE_ESCAPED;
        end else if (i_cfg_we) begin
            if (i_cfg_index == efr_pkg::CFG_DEVICE_ADDRESS) begin
                r_dev_addr <= i_cfg_data;
            end else begin
                r_mode <= efr_pkg::t_mode'(i_cfg_data[0]);
            end
        end
    end

    // per-byte update
    always_comb begin
        n_count   = r_count;
        n_esc     = r_esc;
        n_started = r_started;
        n_pay_len = r_pay_len;
        n_check   = r_check;
        n_leg_len = r_leg_len;
        n_addr    = r_addr;
        n_last    = r_last;
        n_res     = '0;
        store     = 1'b0;
        cnt0      = r_count;
        cnt1      = r_count + 8'd1;

        if (r_count > efr_pkg::MAX_FILL) begin
            n_count = '0;
        end else if (r_mode == efr_pkg::MODE_LEGACY) begin
            if (i_rx_byte == efr_pkg::COLON_BYTE) begin
                cnt0 = '0;
            end
            cnt1             = cnt0 + 8'd1;
            n_res.byte_kept  = 1'b1;
            n_res.kept_index = cnt0;
            n_res.kept_byte  = i_rx_byte;
            if (cnt0 == efr_pkg::POS_LEGACY_LEN) begin
                n_leg_len = i_rx_byte;
            end
            n_count = cnt1;
            if (cnt1 > 8'd1 && n_leg_len == cnt1 - efr_pkg::LEGACY_EXTRA) begin
                n_res.frame_done  = 1'b1;
                n_res.checksum_ok = 1'b1;
                n_res.address_ok  = 1'b1;
                n_res.frame_bytes = cnt1;
                n_count           = '0;
            end
        end else begin
            if (i_rx_byte == efr_pkg::ESC_BYTE) begin
                store = 1'b1;
                n_esc = 1'b1;
            end else if (i_rx_byte == efr_pkg::START_BYTE) begin
                if (r_esc) begin
                    n_check           = efr_pkg::START_CHECK;
                    n_last            = efr_pkg::START_BYTE;
                    n_started         = 1'b1;
                    n_count           = efr_pkg::START_COUNT;
                    n_res.frame_start = 1'b1;
                    n_res.byte_kept   = 1'b1;
                    n_res.kept_index  = efr_pkg::POS_START;
                    n_res.kept_byte   = i_rx_byte;
                end else begin
                    store = 1'b1;
                end
                n_esc = 1'b0;
            end else if (i_rx_byte == efr_pkg::STUFF_BYTE) begin
                // stuffing after an escape is dropped
                if (r_esc) begin
                    n_esc = 1'b0;
                end else begin
                    store = 1'b1;
                end
            end else if (r_started) begin
                store = 1'b1;
                n_esc = 1'b0;
            end

            if (store) begin
                n_res.byte_kept  = 1'b1;
                n_res.kept_index = r_count;
                n_res.kept_byte  = i_rx_byte;
                if (r_count == '0) begin
                    n_check = '0;
                end else begin
                    n_check = efr_pkg::fold(r_check, r_last);
                end
                n_last = i_rx_byte;
                if (r_count == efr_pkg::POS_ADDRESS) begin
                    n_addr = i_rx_byte;
                end
                if (r_count == efr_pkg::POS_LENGTH) begin
                    n_pay_len = i_rx_byte;
                end
                n_count = cnt1;
            end

            if (n_count > efr_pkg::HEADER_BYTES &&
                {1'b0, n_count} == {1'b0, efr_pkg::HEADER_BYTES} + {1'b0, n_pay_len}) begin
                n_res.frame_done  = 1'b1;
                n_res.checksum_ok = (n_last == n_check);
                n_res.address_ok  = (n_addr == r_dev_addr);
                n_res.frame_bytes = n_count;
                n_esc             = 1'b0;
                n_started         = 1'b0;
                n_count           = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_esc     <= 1'b0;
            r_started <= 1'b0;
            r_pay_len <= '0;
            r_check   <= '0;
            r_leg_len <= '0;
            r_addr    <= '0;
            r_last    <= '0;
        end else if (rx_acc) begin
            r_count   <= n_count;
            r_esc     <= n_esc;
            r_started <= n_started;
            r_pay_len <= n_pay_len;
            r_check   <= n_check;
            r_leg_len <= n_leg_len;
            r_addr    <= n_addr;
            r_last    <= n_last;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rx_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_acc) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_byte_kept   = r_res.byte_kept;
    assign o_kept_byte   = r_res.kept_byte;
    assign o_kept_index  = r_res.kept_index;
    assign o_frame_start = r_res.frame_start;
    assign o_frame_done  = r_res.frame_done;
    assign o_checksum_ok = r_res.checksum_ok;
    assign o_address_ok  = r_res.address_ok;
    assign o_frame_bytes = r_res.frame_bytes;

`ifndef SYNTHESIS
    // a completed frame always leaves the count cleared
    a_done_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_acc && n_res.frame_done |=> r_count == '0)
        else $error("count not cleared after frame end");

    // a start pair is reported as the stored 0x29 at position 2
    a_start_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.frame_start |->
            r_res.byte_kept && r_res.kept_index == efr_pkg::POS_START &&
            r_res.kept_byte == efr_pkg::START_BYTE)
        else $error("start item not at position 2");

    // a dropped byte reports nothing
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.byte_kept |->
            r_res.kept_byte == '0 && r_res.kept_index == '0)
        else $error("dropped item carries data");

    // an empty result register never holds off the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_rx_stall)
        else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire
